FILE: design/point_cluster_bounds_centroid_macros.svh
// Assertion macros shared by the cluster bounds and centroid modules.
`ifndef POINT_CLUSTER_BOUNDS_CENTROID_MACROS_SVH
`define POINT_CLUSTER_BOUNDS_CENTROID_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PCBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PCBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pcbc_pkg.sv
// Shared types and constants for the cluster bounds and centroid block.
package pcbc_pkg;

  localparam int MAX_POINTS_DEF = 65536;
  localparam int COORD_BITS_DEF = 20;
  localparam int NUM_AXES       = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_HOLD
  } pcbc_state_t;

  typedef struct packed {
    logic accept;  // point request taken this cycle
    logic load;    // that point closes the cluster: snapshot and clear
    logic start;   // divider lanes take the snapshot sums
    logic step;    // one quotient bit per lane
  } pcbc_cmd_t;

  typedef struct packed {
    logic div_last;  // divider is on its final bit
  } pcbc_sts_t;

endpackage

FILE: design/pcbc_div.sv
// One bit-serial signed divider lane: sum / count, truncated toward zero.
module pcbc_div #(
  parameter int SUM_BITS   = 36,
  parameter int CNT_BITS   = 17,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         start,
  input  logic                         step,
  input  logic signed [SUM_BITS-1:0]   dividend,
  input  logic        [CNT_BITS-1:0]   divisor,
  output logic signed [COORD_BITS-1:0] quot
);

  logic [SUM_BITS-1:0] q_r, q_nxt;
  logic [CNT_BITS-1:0] rem_r, rem_nxt;
  logic                neg_r;
  logic [CNT_BITS:0]   trial;
  logic [CNT_BITS:0]   diff;
  logic                ge;

  always_comb begin
    trial   = {rem_r, q_r[SUM_BITS-1]};
    diff    = trial - {1'b0, divisor};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    q_nxt   = {q_r[SUM_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_BITS-1];
      q_r   <= dividend[SUM_BITS-1] ? (SUM_BITS'(0) - dividend) : dividend;
      rem_r <= '0;
    end else if (step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // magnitude never exceeds the largest coordinate magnitude
  assign quot = neg_r ? (COORD_BITS'(0) - q_r[COORD_BITS-1:0]) : q_r[COORD_BITS-1:0];

endmodule

FILE: design/pcbc_dpath.sv
// Datapath: running min/max/sum/count, result snapshot and divider lanes.
`include "point_cluster_bounds_centroid_macros.svh"

module pcbc_dpath #(
  parameter int MAX_POINTS = pcbc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pcbc_pkg::COORD_BITS_DEF,
  parameter int CNT_BITS   = $clog2(MAX_POINTS + 1),
  parameter int SUM_BITS   = COORD_BITS + $clog2(MAX_POINTS)
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  pcbc_pkg::pcbc_cmd_t                            cmd,
  output pcbc_pkg::pcbc_sts_t                            sts,
  input  logic [pcbc_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  coord,
  output logic [pcbc_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  lo,
  output logic [pcbc_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  hi,
  output logic [pcbc_pkg::NUM_AXES-1:0][COORD_BITS-1:0]  mean,
  output logic [CNT_BITS-1:0]                            point_count,
  output logic                                           count_overflow
);

  localparam int STEP_BITS = $clog2(SUM_BITS);
  localparam logic signed [COORD_BITS-1:0] MOST_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_POINTS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);

  logic signed [COORD_BITS-1:0] min_r [pcbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] max_r [pcbc_pkg::NUM_AXES];
  logic signed [SUM_BITS-1:0]   sum_r [pcbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] min_nxt [pcbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] max_nxt [pcbc_pkg::NUM_AXES];
  logic signed [SUM_BITS-1:0]   sum_nxt [pcbc_pkg::NUM_AXES];
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic                         over_r, over_nxt;
  logic                         full;

  logic signed [COORD_BITS-1:0] lo_r  [pcbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] hi_r  [pcbc_pkg::NUM_AXES];
  logic signed [SUM_BITS-1:0]   snap_sum_r [pcbc_pkg::NUM_AXES];
  logic [CNT_BITS-1:0]          snap_cnt_r;
  logic                         snap_over_r;
  logic [STEP_BITS-1:0]         step_r;

  assign full = (cnt_r == CNT_FULL);

  always_comb begin
    for (int a = 0; a < pcbc_pkg::NUM_AXES; a++) begin
      min_nxt[a] = ($signed(coord[a]) < min_r[a]) ? $signed(coord[a]) : min_r[a];
      max_nxt[a] = ($signed(coord[a]) > max_r[a]) ? $signed(coord[a]) : max_r[a];
      // past the bound a point only widens the box
      sum_nxt[a] = full ? sum_r[a] : (sum_r[a] + SUM_BITS'($signed(coord[a])));
    end
    cnt_nxt  = full ? cnt_r : (cnt_r + CNT_BITS'(1));
    over_nxt = over_r | full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < pcbc_pkg::NUM_AXES; a++) begin
        min_r[a] <= MOST_POS;
        max_r[a] <= MOST_NEG;
        sum_r[a] <= '0;
      end
      cnt_r  <= '0;
      over_r <= 1'b0;
    end else if (cmd.accept) begin
      for (int a = 0; a < pcbc_pkg::NUM_AXES; a++) begin
        min_r[a] <= cmd.load ? MOST_POS : min_nxt[a];
        max_r[a] <= cmd.load ? MOST_NEG : max_nxt[a];
        sum_r[a] <= cmd.load ? '0 : sum_nxt[a];
      end
      cnt_r  <= cmd.load ? '0 : cnt_nxt;
      over_r <= cmd.load ? 1'b0 : over_nxt;
    end
  end

  // result snapshot; held until the result request is taken
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < pcbc_pkg::NUM_AXES; a++) begin
        lo_r[a]       <= min_nxt[a];
        hi_r[a]       <= max_nxt[a];
        snap_sum_r[a] <= sum_nxt[a];
      end
      snap_cnt_r  <= cnt_nxt;
      snap_over_r <= over_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.start) begin
      step_r <= STEP_LAST;
    end else if (cmd.step && (step_r != '0)) begin
      step_r <= step_r - STEP_BITS'(1);
    end
  end

  assign sts.div_last = (step_r == '0);

  for (genvar g = 0; g < pcbc_pkg::NUM_AXES; g++) begin : g_lane
    pcbc_div #(
      .SUM_BITS  (SUM_BITS),
      .CNT_BITS  (CNT_BITS),
      .COORD_BITS(COORD_BITS)
    ) u_div (
      .clk     (clk),
      .start   (cmd.start),
      .step    (cmd.step),
      .dividend(snap_sum_r[g]),
      .divisor (snap_cnt_r),
      .quot    (mean[g])
    );
    assign lo[g] = lo_r[g];
    assign hi[g] = hi_r[g];
  end

  assign point_count    = snap_cnt_r;
  assign count_overflow = snap_over_r;

  `PCBC_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_FULL, "point count past bound")
  `PCBC_ASSERT_NEXT(a_load_clears, clk, rst_n, cmd.accept && cmd.load, (cnt_r == '0) && !over_r && (snap_cnt_r != '0), "cluster state not cleared")

endmodule

FILE: design/pcbc_ctrl.sv
// Controller: request handshakes and sequencing of the divider lanes.
`include "point_cluster_bounds_centroid_macros.svh"

module pcbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic                in_last_point,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pcbc_pkg::pcbc_cmd_t cmd,
  input  pcbc_pkg::pcbc_sts_t sts
);

  pcbc_pkg::pcbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcbc_pkg::ST_IDLE: if (in_vld && in_last_point) state_nxt = pcbc_pkg::ST_PREP;
      pcbc_pkg::ST_PREP: state_nxt = pcbc_pkg::ST_DIV;
      pcbc_pkg::ST_DIV:  if (sts.div_last) state_nxt = pcbc_pkg::ST_HOLD;
      pcbc_pkg::ST_HOLD: if (out_ready) state_nxt = pcbc_pkg::ST_IDLE;
      default:           state_nxt = pcbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    // points keep flowing; only a cluster end waits for the divider and for the result to be taken
    in_ready   = (state_r == pcbc_pkg::ST_IDLE) || !in_last_point;
    out_valid  = (state_r == pcbc_pkg::ST_HOLD);
    cmd.accept = in_vld && in_ready;
    cmd.load   = cmd.accept && in_last_point;
    cmd.start  = (state_r == pcbc_pkg::ST_PREP);
    cmd.step   = (state_r == pcbc_pkg::ST_DIV);
  end

  `PCBC_ASSERT_NOW(a_load_idle, clk, rst_n, cmd.load, state_r == pcbc_pkg::ST_IDLE, "load while divider busy")
  `PCBC_ASSERT_NEXT(a_prep_div, clk, rst_n, state_r == pcbc_pkg::ST_PREP, cmd.step && !out_valid, "divider did not start")
  `PCBC_ASSERT_NEXT(a_div_done, clk, rst_n, cmd.step && sts.div_last, out_valid, "result not presented after last bit")

endmodule

FILE: design/point_cluster_bounds_centroid.sv
// Cluster bounds and centroid: takes one point per cycle while in_ready is
// high and, on a point marked last, gives the min and max corners, the
// per-axis mean truncated toward zero, the point count and an overflow flag.
// Points past MAX_POINTS widen the box but are left out of count and mean.
// Each axis mean comes from a restoring divider that makes one quotient bit
// per cycle; a result is offered once the snapshot, the PREP state and the
// DIV state have run. Points of the next cluster are taken at one per cycle
// meanwhile; only its last point waits until the previous result has been
// taken.
module point_cluster_bounds_centroid #(
  parameter int MAX_POINTS = pcbc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pcbc_pkg::COORD_BITS_DEF,
  parameter int CNT_BITS   = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_lo_x,
  output logic signed [COORD_BITS-1:0] out_lo_y,
  output logic signed [COORD_BITS-1:0] out_lo_z,
  output logic signed [COORD_BITS-1:0] out_hi_x,
  output logic signed [COORD_BITS-1:0] out_hi_y,
  output logic signed [COORD_BITS-1:0] out_hi_z,
  output logic signed [COORD_BITS-1:0] out_mean_x,
  output logic signed [COORD_BITS-1:0] out_mean_y,
  output logic signed [COORD_BITS-1:0] out_mean_z,
  output logic        [CNT_BITS-1:0]   out_point_count,
  output logic                         out_count_overflow
);

  pcbc_pkg::pcbc_cmd_t cmd;
  pcbc_pkg::pcbc_sts_t sts;
  logic [pcbc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] coord, lo, hi, mean;

  assign coord = {in_coord_z, in_coord_y, in_coord_x};

  pcbc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (in_vld),
    .in_last_point(in_last_point),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  pcbc_dpath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .CNT_BITS  (CNT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .coord         (coord),
    .lo            (lo),
    .hi            (hi),
    .mean          (mean),
    .point_count   (out_point_count),
    .count_overflow(out_count_overflow)
  );

  assign out_lo_x   = lo[0];
  assign out_lo_y   = lo[1];
  assign out_lo_z   = lo[2];
  assign out_hi_x   = hi[0];
  assign out_hi_y   = hi[1];
  assign out_hi_z   = hi[2];
  assign out_mean_x = mean[0];
  assign out_mean_y = mean[1];
  assign out_mean_z = mean[2];

endmodule
